/* rtl/core/mi3_pkg.sv */
// Shared widths and payload types of the 3x3 matrix inverse.
`timescale 1ns / 1ps

package mi3_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int CFG_W       = 31;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int COF_W       = PROD_W + 1;
  localparam int COF_LO_W    = COF_W - WORD_W;
  localparam int PL_W        = WORD_W + COF_LO_W + 1;
  localparam int DET_W       = WORD_W + COF_W + 2;
  localparam int DMAG_W      = DET_W - 1;
  localparam int NUM_W       = COF_W + 2 * FRAC_W;
  localparam int CMP_W       = NUM_W + DMAG_W;
  localparam int FRONT_STAGES = 6;
  localparam int DIV_STAGES  = WORD_W + 1;
  localparam int PIPE_DEPTH  = FRONT_STAGES + DIV_STAGES;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t a00; word_t a01; word_t a02;
    word_t a10; word_t a11; word_t a12;
    word_t a20; word_t a21; word_t a22;
  } in_t;

  typedef struct packed {
    word_t r00; word_t r01; word_t r02;
    word_t r10; word_t r11; word_t r12;
    word_t r20; word_t r21; word_t r22;
    logic  singular;
  } out_t;

endpackage

/* rtl/core/mi3_div.sv */
// Pipelined restoring divider: one quotient bit per stage, then round and saturate.
`timescale 1ns / 1ps

module mi3_div import mi3_pkg::*; (
  input  logic                    clk,
  input  logic [DIV_STAGES-1:0]   en,
  input  logic [NUM_W-1:0]        num,
  input  logic [DMAG_W-1:0]       den,
  input  logic                    neg,
  input  logic                    big,
  input  logic                    zero,
  output word_t                   res
);

  logic [NUM_W-1:0]  rem  [0:WORD_W];
  logic [WORD_W-1:0] quo  [0:WORD_W];
  logic [DMAG_W-1:0] dv   [0:WORD_W];
  logic              ng   [0:WORD_W];
  logic              bg   [0:WORD_W];
  logic              zr   [0:WORD_W];

  assign rem[0] = num;
  assign quo[0] = '0;
  assign dv[0]  = den;
  assign ng[0]  = neg;
  assign bg[0]  = big;
  assign zr[0]  = zero;

  for (genvar k = 0; k < WORD_W; k++) begin : g_stage
    localparam int BITPOS = WORD_W - 1 - k;
    logic [CMP_W-1:0] remx;
    logic [CMP_W-1:0] dsx;
    logic             take;
    assign remx = CMP_W'(rem[k]);
    assign dsx  = CMP_W'(dv[k]) << BITPOS;
    assign take = remx >= dsx;
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k+1] <= take ? NUM_W'(remx - dsx) : rem[k];
        quo[k+1] <= quo[k] | (take ? (WORD_W'(1) << BITPOS) : '0);
        dv[k+1]  <= dv[k];
        ng[k+1]  <= ng[k];
        bg[k+1]  <= bg[k];
        zr[k+1]  <= zr[k];
      end
    end
  end

  logic [WORD_W:0] qr;
  logic [WORD_W:0] lim;
  logic [WORD_W:0] mag;
  logic            up;

  always_comb begin
    up  = (CMP_W'(rem[WORD_W]) << 1) >= CMP_W'(dv[WORD_W]);
    qr  = {1'b0, quo[WORD_W]} + (WORD_W+1)'(up);
    lim = ng[WORD_W] ? ((WORD_W+1)'(1) << (WORD_W-1))
                     : ((WORD_W+1)'(1) << (WORD_W-1)) - (WORD_W+1)'(1);
    mag = (bg[WORD_W] || qr > lim) ? lim : qr;
  end

  always_ff @(posedge clk) begin
    if (en[WORD_W]) begin
      if (zr[WORD_W]) res <= '0;
      else if (ng[WORD_W]) res <= word_t'(-mag);
      else res <= word_t'(mag);
    end
  end

endmodule

/* rtl/core/matrix_inverse_3x3.sv */
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
// Usage:
//   mat channel: one 3x3 matrix per transfer, nine signed Q16.16 entries.
//   inv channel: the inverse, nine signed Q16.16 entries rounded to nearest
//     and saturated, plus the singular flag (all entries zero when set).
//   cfg channel: writes det_threshold; always ready, write it while idle.
// Pipeline: there are 39 register stages (6 front stages for products,
//   cofactors, determinant and magnitude tests, 32 divider bit stages and
//   one round/saturate stage that is also the output register); the first
//   loads at the transfer edge.
// Throughput: one matrix per cycle while inv_ready holds; nine dividers run
//   side by side, one quotient bit per stage, so every stage takes a new item each cycle unless stalled.
// Reset: clears all stage valid bits and sets det_threshold to zero.
// Stall: each stage holds while the next is full and stalled; empty stages
//   keep filling, so mat_ready stays high until the pipe has no bubble left.
`timescale 1ns / 1ps

module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             mat_valid,
  output logic             mat_ready,
  input  in_t              mat,
  output logic             inv_valid,
  input  logic             inv_ready,
  output out_t             inv,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // minor index table: cof[i] = a[MP]*a[MQ] - a[MS]*a[MU]
  localparam int MP [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int MQ [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int MS [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int MU [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam int DC [3] = '{0, 3, 6};

  logic [CFG_W-1:0] det_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) det_threshold <= '0;
    else if (cfg_valid) det_threshold <= cfg_data;
  end

  // stage valids; a stage advances when empty or when the next one advances
  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] adv;

  assign adv[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || inv_ready;
  for (genvar k = 0; k < PIPE_DEPTH - 1; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else begin
      if (adv[0]) vld[0] <= mat_valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign mat_ready = adv[0];
  assign inv_valid = vld[PIPE_DEPTH-1];

  word_t a_in [9];
  assign a_in = '{mat.a00, mat.a01, mat.a02, mat.a10, mat.a11, mat.a12,
                  mat.a20, mat.a21, mat.a22};

  // stage 1: the eighteen minor products
  logic signed [PROD_W-1:0] px [9];
  logic signed [PROD_W-1:0] py [9];
  word_t                    ar1 [3];
  // stage 2: cofactors
  logic signed [COF_W-1:0]  cof2 [9];
  word_t                    ar2 [3];
  // stage 3: determinant partial products, cofactor split in high and low part
  logic signed [PROD_W-1:0] ph [3];
  logic signed [PL_W-1:0]   pl [3];
  logic signed [COF_W-1:0]  cof3 [9];
  // stage 4: determinant
  logic signed [DET_W-1:0]  det;
  logic signed [COF_W-1:0]  cof4 [9];
  // stage 5: magnitudes and signs
  logic [DMAG_W-1:0]        dmag;
  logic                     dneg;
  logic [COF_W-1:0]         cmag [9];
  logic                     cneg [9];
  logic                     czero [9];
  // stage 6: singular and overflow tests, divider operands
  logic [NUM_W-1:0]         num6 [9];
  logic [DMAG_W-1:0]        den6;
  logic                     neg6 [9];
  logic                     big6 [9];
  logic                     zero6 [9];
  logic                     czero_q [9];
  logic                     sing [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 9; i++) begin
        px[i] <= a_in[MP[i]] * a_in[MQ[i]];
        py[i] <= a_in[MS[i]] * a_in[MU[i]];
      end
      for (int j = 0; j < 3; j++) ar1[j] <= a_in[j];
    end
    if (adv[1]) begin
      for (int i = 0; i < 9; i++) cof2[i] <= COF_W'(px[i]) - COF_W'(py[i]);
      ar2 <= ar1;
    end
    if (adv[2]) begin
      for (int j = 0; j < 3; j++) begin
        ph[j] <= ar2[j] * $signed(cof2[DC[j]][COF_W-1:COF_LO_W]);
        pl[j] <= ar2[j] * $signed({1'b0, cof2[DC[j]][COF_LO_W-1:0]});
      end
      cof3 <= cof2;
    end
    if (adv[3]) begin
      det <= (DET_W'(ph[0]) <<< COF_LO_W) + DET_W'(pl[0])
           + (DET_W'(ph[1]) <<< COF_LO_W) + DET_W'(pl[1])
           + (DET_W'(ph[2]) <<< COF_LO_W) + DET_W'(pl[2]);
      cof4 <= cof3;
    end
    if (adv[4]) begin
      dneg <= det[DET_W-1];
      dmag <= det[DET_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
      for (int i = 0; i < 9; i++) begin
        cneg[i]  <= cof4[i][COF_W-1];
        cmag[i]  <= cof4[i][COF_W-1] ? COF_W'(-cof4[i]) : COF_W'(cof4[i]);
        czero[i] <= cof4[i] == '0;
      end
    end
    if (adv[5]) begin
      sing[0] <= (dmag == '0) || (dmag < (DMAG_W'(det_threshold) << (2 * FRAC_W)));
      den6    <= dmag;
      for (int i = 0; i < 9; i++) begin
        num6[i] <= NUM_W'(cmag[i]) << (2 * FRAC_W);
        neg6[i] <= cneg[i] ^ dneg;
        // quotient reaches 2^WORD_W or more: saturate, the divider result is not used
        big6[i] <= (CMP_W'(cmag[i]) << (2 * FRAC_W)) >= (CMP_W'(dmag) << WORD_W);
      end
    end
  end

  // drop every entry to zero when singular, or when the cofactor is zero
  always_comb begin
    for (int i = 0; i < 9; i++) zero6[i] = czero_q[i] || sing[0];
  end

  always_ff @(posedge clk) begin
    if (adv[5]) czero_q <= czero;
  end

  // singular flag travels beside the dividers
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_sing
    always_ff @(posedge clk) begin
      if (adv[FRONT_STAGES+k]) sing[k+1] <= sing[k];
    end
  end

  word_t res [9];
  for (genvar i = 0; i < 9; i++) begin : g_div
    mi3_div u_div (
      .clk  (clk),
      .en   (adv[PIPE_DEPTH-1:FRONT_STAGES]),
      .num  (num6[i]),
      .den  (den6),
      .neg  (neg6[i]),
      .big  (big6[i]),
      .zero (zero6[i]),
      .res  (res[i])
    );
  end

  assign inv = '{r00: res[0], r01: res[1], r02: res[2],
                 r10: res[3], r11: res[4], r12: res[5],
                 r20: res[6], r21: res[7], r22: res[8],
                 singular: sing[DIV_STAGES]};

endmodule

/* rtl/core/mi3_chk.sv */
// Port-level checker for the matrix inverse, bound to the top level.
`timescale 1ns / 1ps

module mi3_chk import mi3_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             mat_ready,
  input logic             inv_valid,
  input logic             inv_ready,
  input out_t             inv,
  input logic             cfg_ready
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !inv_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    inv_valid && !inv_ready |=> inv_valid && $stable(inv))
    else $error("stalled result changed");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv.singular |->
      inv.r00 == '0 && inv.r01 == '0 && inv.r02 == '0 &&
      inv.r10 == '0 && inv.r11 == '0 && inv.r12 == '0 &&
      inv.r20 == '0 && inv.r21 == '0 && inv.r22 == '0)
    else $error("singular result with nonzero entry");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !inv_valid |-> mat_ready)
    else $error("input stalled with empty output");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind matrix_inverse_3x3 mi3_chk u_chk (.*);
